// ===== rtl/mrpts_pkg.sv =====
package mrpts_pkg;

   typedef struct packed {
      logic        kind;
      logic [31:0] period_ms;
   } req_type;

   typedef struct packed {
      logic [1:0]  event_res;
      logic [3:0]  series_index;
      logic [31:0] tick_period;
      logic        last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GCD,
      ST_READ,
      ST_EVAL,
      ST_DONE
   } state_type;

   localparam logic KIND_REGISTER = 1'b0;
   localparam logic KIND_TICK     = 1'b1;

   localparam logic [1:0] EV_REGISTERED = 2'd0;
   localparam logic [1:0] EV_FIRED      = 2'd1;
   localparam logic [1:0] EV_FULL       = 2'd2;

endpackage

// ===== rtl/mrpts_ram.sv =====
module mrpts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/multi_rate_periodic_tick_scheduler_top.sv =====
// Register beat: table full answers in the cycle after start; otherwise a binary
// gcd runs one step per cycle, then answers.
// Tick beat: per registered series, a memory read then an update; then done.
// One beat at a time; busy stays high until the last result has been issued.
// Synchronous reset clears series count, metronome period and control; the
// series memory needs no clearing pass. Results are strobes and cannot be stalled.
module multi_rate_periodic_tick_scheduler_top #(
   parameter int MAX_SERIES  = 16,
   parameter int PERIOD_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  mrpts_pkg::req_type req_data,
   output logic              rsp_strobe,
   output mrpts_pkg::rsp_type rsp_data
);

   localparam int PB     = PERIOD_BITS;
   localparam int IDX_W  = (MAX_SERIES > 1) ? $clog2(MAX_SERIES) : 1;
   localparam int CNT_W  = $clog2(MAX_SERIES + 1);
   localparam int K_W    = $clog2(PERIOD_BITS + 1);
   localparam int MEM_W  = 2 * PERIOD_BITS + 1;

   mrpts_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [PB-1:0]     metro_ff, metro_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [PB-1:0]     a_ff, a_in, b_ff, b_in, p_ff, p_in;
   logic [K_W-1:0]    k_ff, k_in;
   logic              pend_ff, pend_in;
   logic [IDX_W-1:0]  pend_idx_ff, pend_idx_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   mrpts_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic              wr_en, rd_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [MEM_W-1:0]  wr_data, rd_data;

   logic [PB+31:0]    p_ext;
   logic [PB-1:0]     p_req;
   logic [PB-1:0]     per, gcd_val;
   logic [PB:0]       acc, acc_sum, per_gap;
   logic [PB:0]       diff_ab, diff_ba;
   logic              fire, accept, is_last, full;
   logic [IDX_W-1:0]  out_idx;
   logic [IDX_W+3:0]  out_idx_ext;
   logic [PB+31:0]    metro_ext;

   mrpts_ram #(
      .WIDTH (MEM_W),
      .DEPTH (MAX_SERIES)
   ) u_series_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign accept  = start && (state_ff == mrpts_pkg::ST_IDLE);
   assign busy    = (state_ff != mrpts_pkg::ST_IDLE);
   assign p_ext   = {{PB{1'b0}}, req_data.period_ms};
   assign p_req   = p_ext[PB-1:0];
   assign full    = (count_ff == CNT_W'(MAX_SERIES));
   assign is_last = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);

   assign per     = rd_data[MEM_W-1 -: PB];
   assign acc     = rd_data[PB:0];
   assign per_gap = {1'b0, per} - {1'b0, metro_ff};
   assign acc_sum = acc + {1'b0, metro_ff};
   assign fire    = (metro_ff >= per) || (acc >= per_gap);

   assign diff_ab = {1'b0, a_ff} - {1'b0, b_ff};
   assign diff_ba = {1'b0, b_ff} - {1'b0, a_ff};
   assign gcd_val = ((a_ff == '0) ? b_ff : a_ff) << k_ff;

   assign out_idx_ext = {4'b0, out_idx};
   assign metro_ext   = {32'b0, metro_in};

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      metro_in      = metro_ff;
      idx_in        = idx_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      k_in          = k_ff;
      p_in          = p_ff;
      pend_in       = pend_ff;
      pend_idx_in   = pend_idx_ff;
      rsp_strobe_in = 1'b0;
      out_idx       = '0;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = '0;
      rd_en         = 1'b0;
      rsp_data_in.event_res = mrpts_pkg::EV_FIRED;
      rsp_data_in.last      = 1'b0;

      case (state_ff)
         mrpts_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_data.kind == mrpts_pkg::KIND_REGISTER) begin
                  if (full) begin
                     rsp_strobe_in         = 1'b1;
                     rsp_data_in.event_res = mrpts_pkg::EV_FULL;
                     rsp_data_in.last      = 1'b1;
                  end else begin
                     a_in     = p_req;
                     b_in     = metro_ff;
                     k_in     = '0;
                     p_in     = p_req;
                     state_in = mrpts_pkg::ST_GCD;
                  end
               end else if (count_ff != '0) begin
                  idx_in   = '0;
                  pend_in  = 1'b0;
                  state_in = mrpts_pkg::ST_READ;
               end
            end
         end
         mrpts_pkg::ST_GCD: begin
            if ((a_ff == '0) || (b_ff == '0)) begin
               // gcd settled: append the series with a cleared accumulator
               metro_in              = gcd_val;
               wr_en                 = 1'b1;
               wr_addr               = count_ff[IDX_W-1:0];
               wr_data               = {p_ff, {(PB+1){1'b0}}};
               count_in              = count_ff + CNT_W'(1);
               out_idx               = count_ff[IDX_W-1:0];
               rsp_strobe_in         = 1'b1;
               rsp_data_in.event_res = mrpts_pkg::EV_REGISTERED;
               rsp_data_in.last      = 1'b1;
               state_in              = mrpts_pkg::ST_IDLE;
            end else if (!a_ff[0] && !b_ff[0]) begin
               a_in = a_ff >> 1;
               b_in = b_ff >> 1;
               k_in = k_ff + K_W'(1);
            end else if (!a_ff[0]) begin
               a_in = a_ff >> 1;
            end else if (!b_ff[0]) begin
               b_in = b_ff >> 1;
            end else if (!diff_ab[PB]) begin
               a_in = diff_ab[PB:1];
            end else begin
               b_in = diff_ba[PB:1];
            end
         end
         mrpts_pkg::ST_READ: begin
            rd_en    = 1'b1;
            state_in = mrpts_pkg::ST_EVAL;
         end
         mrpts_pkg::ST_EVAL: begin
            wr_en   = 1'b1;
            wr_data = {per, fire ? {(PB+1){1'b0}} : acc_sum};
            if (fire) begin
               // hold one firing back so the final one can carry last
               if (pend_ff) begin
                  rsp_strobe_in = 1'b1;
                  out_idx       = pend_idx_ff;
               end
               pend_in     = 1'b1;
               pend_idx_in = idx_ff;
            end
            if (is_last) begin
               state_in = mrpts_pkg::ST_DONE;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = mrpts_pkg::ST_READ;
            end
         end
         mrpts_pkg::ST_DONE: begin
            if (pend_ff) begin
               rsp_strobe_in    = 1'b1;
               out_idx          = pend_idx_ff;
               rsp_data_in.last = 1'b1;
            end
            pend_in  = 1'b0;
            state_in = mrpts_pkg::ST_IDLE;
         end
         default: begin
            state_in = mrpts_pkg::ST_IDLE;
         end
      endcase

      rsp_data_in.series_index = out_idx_ext[3:0];
      rsp_data_in.tick_period  = metro_ext[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mrpts_pkg::ST_IDLE;
         count_ff      <= '0;
         metro_ff      <= '0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         metro_ff      <= metro_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      k_ff        <= k_in;
      p_ff        <= p_in;
      pend_idx_ff <= pend_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule
